// File: rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants and types of the 4x4 fixed point matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

  localparam int unsigned DIM = 4;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned NUM_ELEMS = DIM * DIM;
  localparam int unsigned CNT_W = 2 * IDX_W;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic OPERAND_LEFT = 1'b0;
  localparam logic OPERAND_RIGHT = 1'b1;

  // product element travelling down the chain
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } tok_t;

endpackage

`default_nettype wire

// File: rtl/mm4_cell.sv
// ----------------------------------------------------------------------------
// mm4_cell
// One multiply-accumulate cell. Holds one column of the left matrix and the
// matching row of the right matrix, multiplies the pair chosen by the passing
// element and adds the product to the partial sum handed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_cell #(
  parameter int unsigned VALUE_WIDTH = mm4_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             left_we_i,
  input  wire logic                             right_we_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]        wr_addr_left_i,
  input  wire logic [mm4_pkg::IDX_W-1:0]        wr_addr_right_i,
  input  wire logic [VALUE_WIDTH-1:0]           wr_data_i,
  input  wire logic                             vld_i,
  input  wire mm4_pkg::tok_t                    tok_i,
  input  wire logic [2*VALUE_WIDTH+1:0]         sum_i,
  output logic                                  vld_o,
  output mm4_pkg::tok_t                         tok_o,
  output logic [2*VALUE_WIDTH+1:0]              sum_o,
  output logic                                  busy_o
);

  localparam int unsigned ProdW = 2 * VALUE_WIDTH;
  localparam int unsigned AccW = ProdW + 2;

  logic [VALUE_WIDTH-1:0] left_q  [mm4_pkg::DIM];
  logic [VALUE_WIDTH-1:0] right_q [mm4_pkg::DIM];

  logic                   vld_a_q;
  mm4_pkg::tok_t          tok_a_q;
  logic [AccW-1:0]        psum_a_q;
  logic [ProdW-1:0]       prod_a_q;
  logic [ProdW-1:0]       prod_d;

  logic                   vld_b_q;
  mm4_pkg::tok_t          tok_b_q;
  logic [AccW-1:0]        sum_b_q;
  logic [AccW-1:0]        sum_d;

  // operand stores, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mm4_pkg::DIM; i++) begin
        left_q[i]  <= '0;
        right_q[i] <= '0;
      end
    end else begin
      if (left_we_i) begin
        left_q[wr_addr_left_i] <= wr_data_i;
      end
      if (right_we_i) begin
        right_q[wr_addr_right_i] <= wr_data_i;
      end
    end
  end

  // multiply stage
  assign prod_d = ProdW'($signed(left_q[tok_i.row]) * $signed(right_q[tok_i.col]));

  // accumulate stage
  assign sum_d = psum_a_q + {{2{prod_a_q[ProdW-1]}}, prod_a_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_a_q  <= tok_i;
      psum_a_q <= sum_i;
      prod_a_q <= prod_d;
      tok_b_q  <= tok_a_q;
      sum_b_q  <= sum_d;
    end
  end

  assign vld_o  = vld_b_q;
  assign tok_o  = tok_b_q;
  assign sum_o  = sum_b_q;
  assign busy_o = vld_a_q | vld_b_q;

endmodule

`default_nettype wire

// File: rtl/matrix4x4_multiply_top.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply_top
// 4x4 signed fixed point matrix multiplier built as a chain of four
// multiply-accumulate cells followed by scaling, saturation and an output
// register.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low to high)                    tuser           tlast
//  s_axis    in   row_index, col_index, element_value,   operand_select  -
//                 compute_now
//  m_axis    out  out_row, out_col, product_value        overflow        last_element
//
//  an element write stores one operand entry; a compute item is stored, its
//  sixteen elements are launched into the chain, and the last one leaves the
//  four two-stage cells and is held in the output register
//  the input is held off from the first launch until the chain is empty
//  an output stall freezes the whole chain, the launcher included
//  reset clears both operand matrices and all valid bits at once
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4x4_multiply_top #(
  parameter int unsigned VALUE_WIDTH = mm4_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = mm4_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // row_index[1:0], col_index[3:2], element_value, compute_now, zero pad
  input  wire logic [((VALUE_WIDTH+5+7)/8)*8-1:0]    s_axis_tdata_i,
  // operand_select
  input  wire logic                                  s_axis_tuser_i,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // out_row[1:0], out_col[3:2], product_value, zero pad
  output logic [((VALUE_WIDTH+4+7)/8)*8-1:0]         m_axis_tdata_o,
  // overflow
  output logic                                       m_axis_tuser_o,
  output logic                                       m_axis_tlast_o
);

  localparam int unsigned AccW = 2 * VALUE_WIDTH + 2;
  localparam int unsigned OutW = ((VALUE_WIDTH + 4 + 7) / 8) * 8;
  localparam int unsigned IdxW = mm4_pkg::IDX_W;
  localparam int unsigned CntW = mm4_pkg::CNT_W;
  localparam logic [CntW-1:0] CntLast = CntW'(mm4_pkg::NUM_ELEMS - 1);

  logic                   in_xfer;
  logic [IdxW-1:0]        in_row;
  logic [IdxW-1:0]        in_col;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   in_compute;

  logic                   adv;
  logic                   issuing_q;
  logic [CntW-1:0]        cnt_q;

  logic                   vld_w [mm4_pkg::DIM+1];
  mm4_pkg::tok_t          tok_w [mm4_pkg::DIM+1];
  logic [AccW-1:0]        sum_w [mm4_pkg::DIM+1];
  logic [mm4_pkg::DIM-1:0] busy_w;
  logic                   pipe_busy;

  logic [AccW-1:0]        shifted;
  logic                   fits;
  logic [VALUE_WIDTH-1:0] sat_value;

  logic                   out_vld_q;
  mm4_pkg::tok_t          out_tok_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  logic                   out_ovf_q;

  assign in_row     = s_axis_tdata_i[IdxW-1:0];
  assign in_col     = s_axis_tdata_i[2*IdxW-1:IdxW];
  assign in_value   = s_axis_tdata_i[VALUE_WIDTH+2*IdxW-1:2*IdxW];
  assign in_compute = s_axis_tdata_i[VALUE_WIDTH+2*IdxW];

  assign pipe_busy       = |busy_w;
  assign s_axis_tready_o = !issuing_q && !pipe_busy;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign adv             = !out_vld_q || m_axis_tready_i;

  // element launcher
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      cnt_q     <= '0;
    end else if (in_xfer && in_compute) begin
      issuing_q <= 1'b1;
      cnt_q     <= '0;
    end else if (issuing_q && adv) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        issuing_q <= 1'b0;
      end
    end
  end

  assign vld_w[0]      = issuing_q;
  assign tok_w[0].row  = cnt_q[CntW-1:IdxW];
  assign tok_w[0].col  = cnt_q[IdxW-1:0];
  assign tok_w[0].last = (cnt_q == CntLast);
  assign sum_w[0]      = '0;

  for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_cell
    logic left_we;
    logic right_we;

    // cell k holds left column k and right row k
    assign left_we  = in_xfer && (s_axis_tuser_i == mm4_pkg::OPERAND_LEFT)
                      && (in_col == IdxW'(k));
    assign right_we = in_xfer && (s_axis_tuser_i == mm4_pkg::OPERAND_RIGHT)
                      && (in_row == IdxW'(k));

    mm4_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .en_i            (adv),
      .left_we_i       (left_we),
      .right_we_i      (right_we),
      .wr_addr_left_i  (in_row),
      .wr_addr_right_i (in_col),
      .wr_data_i       (in_value),
      .vld_i           (vld_w[k]),
      .tok_i           (tok_w[k]),
      .sum_i           (sum_w[k]),
      .vld_o           (vld_w[k+1]),
      .tok_o           (tok_w[k+1]),
      .sum_o           (sum_w[k+1]),
      .busy_o          (busy_w[k])
    );
  end

  // scale and saturate
  assign shifted = $signed(sum_w[mm4_pkg::DIM]) >>> FRAC_BITS;
  assign fits    = (&shifted[AccW-1:VALUE_WIDTH-1]) || !(|shifted[AccW-1:VALUE_WIDTH-1]);

  always_comb begin
    if (fits) begin
      sat_value = shifted[VALUE_WIDTH-1:0];
    end else if (shifted[AccW-1]) begin
      sat_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_w[mm4_pkg::DIM];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_tok_q   <= tok_w[mm4_pkg::DIM];
      out_value_q <= sat_value;
      out_ovf_q   <= !fits;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutW'({out_value_q, out_tok_q.col, out_tok_q.row});
  assign m_axis_tuser_o  = out_ovf_q;
  assign m_axis_tlast_o  = out_tok_q.last;

  a_last_is_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |->
      (out_tok_q.row == IdxW'(mm4_pkg::DIM - 1) && out_tok_q.col == IdxW'(mm4_pkg::DIM - 1)))
    else $error("last product element is not the bottom right corner");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_compute) |=> (issuing_q && cnt_q == '0))
    else $error("compute transfer did not start the launcher");

  a_launch_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issuing_q && adv && cnt_q == CntLast) |=> !issuing_q)
    else $error("launcher ran past sixteen elements");

  a_launch_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(issuing_q) |-> $past(in_xfer && in_compute))
    else $error("launcher started without a compute transfer");

endmodule

`default_nettype wire
